### rtl/kst_pkg.sv
// Shared constants and character ROMs for the keyboard scancode translator.
// Holds key numbers, character masks and the plain and shifted lookup tables.
// No dependencies.
package kst_pkg;

    localparam int unsigned SC_W   = 8;
    localparam int unsigned KEY_W  = 7;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned NUM_KEYS = 1 << KEY_W;

    // Key numbers with a special meaning
    localparam logic [KEY_W-1:0] CAPS_KEY      = 7'h2c;
    localparam logic [KEY_W-1:0] CAPS_LOCK_KEY = 7'h70;
    localparam logic [KEY_W-1:0] LSHIFT_KEY    = 7'h12;
    localparam logic [KEY_W-1:0] RSHIFT_KEY    = 7'h62;
    localparam logic [KEY_W-1:0] CONTROL_KEY   = 7'h19;

    // Scancode bit that marks a key release
    localparam int unsigned REL_BIT = 7;

    // Character handling
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [CHAR_W-1:0] CTRL_MASK    = 8'h1f;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

    // Unshifted character for each key number
    function automatic logic [CHAR_W-1:0] plain_rom(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] c;
        unique case (key)
            7'd9:    c = 8'h60;
            7'd10:   c = 8'h5c;
            7'd11:   c = 8'h09;
            7'd12:   c = 8'h7a;
            7'd13:   c = 8'h61;
            7'd14:   c = 8'h78;
            7'd26:   c = 8'h7f;
            7'd41:   c = 8'h1b;
            7'd42:   c = 8'hff;
            7'd43:   c = 8'h71;
            7'd45:   c = 8'h73;
            7'd46:   c = 8'h63;
            7'd47:   c = 8'h33;
            7'd49:   c = 8'h31;
            7'd51:   c = 8'h77;
            7'd53:   c = 8'h64;
            7'd54:   c = 8'h76;
            7'd55:   c = 8'h34;
            7'd57:   c = 8'h32;
            7'd58:   c = 8'h74;
            7'd59:   c = 8'h65;
            7'd61:   c = 8'h66;
            7'd62:   c = 8'h62;
            7'd63:   c = 8'h35;
            7'd65:   c = 8'h39;
            7'd66:   c = 8'h79;
            7'd67:   c = 8'h72;
            7'd68:   c = 8'h6b;
            7'd69:   c = 8'h67;
            7'd70:   c = 8'h6e;
            7'd71:   c = 8'h36;
            7'd73:   c = 8'h30;
            7'd74:   c = 8'h75;
            7'd75:   c = 8'h6f;
            7'd76:   c = 8'h6c;
            7'd77:   c = 8'h68;
            7'd78:   c = 8'h6d;
            7'd79:   c = 8'h37;
            7'd81:   c = 8'h2d;
            7'd82:   c = 8'h69;
            7'd83:   c = 8'h70;
            7'd84:   c = 8'h3b;
            7'd85:   c = 8'h6a;
            7'd86:   c = 8'h2c;
            7'd87:   c = 8'h38;
            7'd89:   c = 8'h3d;
            7'd90:   c = 8'h0a;
            7'd91:   c = 8'h5b;
            7'd92:   c = 8'h27;
            7'd93:   c = 8'h2f;
            7'd94:   c = 8'h2e;
            7'd95:   c = 8'h85;
            7'd105:  c = 8'h08;
            7'd106:  c = 8'h86;
            7'd107:  c = 8'h5d;
            7'd108:  c = 8'h87;
            7'd109:  c = 8'h89;
            7'd110:  c = 8'h20;
            7'd111:  c = 8'h88;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // Shifted character for each key number
    function automatic logic [CHAR_W-1:0] shift_rom(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] c;
        unique case (key)
            7'd9:    c = 8'h7e;
            7'd10:   c = 8'h7c;
            7'd11:   c = 8'h09;
            7'd12:   c = 8'h5a;
            7'd13:   c = 8'h41;
            7'd14:   c = 8'h58;
            7'd26:   c = 8'h7f;
            7'd41:   c = 8'h1b;
            7'd42:   c = 8'hff;
            7'd43:   c = 8'h51;
            7'd45:   c = 8'h53;
            7'd46:   c = 8'h43;
            7'd47:   c = 8'h23;
            7'd49:   c = 8'h21;
            7'd51:   c = 8'h57;
            7'd53:   c = 8'h44;
            7'd54:   c = 8'h56;
            7'd55:   c = 8'h24;
            7'd57:   c = 8'h40;
            7'd58:   c = 8'h54;
            7'd59:   c = 8'h45;
            7'd61:   c = 8'h46;
            7'd62:   c = 8'h42;
            7'd63:   c = 8'h25;
            7'd65:   c = 8'h28;
            7'd66:   c = 8'h59;
            7'd67:   c = 8'h52;
            7'd68:   c = 8'h4b;
            7'd69:   c = 8'h47;
            7'd70:   c = 8'h4e;
            7'd71:   c = 8'h5e;
            7'd73:   c = 8'h29;
            7'd74:   c = 8'h55;
            7'd75:   c = 8'h4f;
            7'd76:   c = 8'h4c;
            7'd77:   c = 8'h48;
            7'd78:   c = 8'h4d;
            7'd79:   c = 8'h26;
            7'd81:   c = 8'h5f;
            7'd82:   c = 8'h49;
            7'd83:   c = 8'h50;
            7'd84:   c = 8'h3a;
            7'd85:   c = 8'h4a;
            7'd86:   c = 8'h3c;
            7'd87:   c = 8'h2a;
            7'd89:   c = 8'h2b;
            7'd90:   c = 8'h0a;
            7'd91:   c = 8'h7b;
            7'd92:   c = 8'h22;
            7'd93:   c = 8'h3f;
            7'd94:   c = 8'h3e;
            7'd95:   c = 8'h85;
            7'd105:  c = 8'h08;
            7'd106:  c = 8'h86;
            7'd107:  c = 8'h7d;
            7'd108:  c = 8'h87;
            7'd109:  c = 8'h89;
            7'd110:  c = 8'h20;
            7'd111:  c = 8'h88;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

### rtl/keyboard_scancode_translator_core.sv
// An accepted scancode is held in the input register, then its translation in the result
// register, which holds it while the output is stalled. One scancode per cycle unless
// the output stalls; the key map update and ROM lookup are combinational.
// Reset (rst_n low, asynchronous): clears the 128-bit key map (no key held, caps lock
// off) and empties both pipeline registers.
// Scancode translator top level; depends on kst_pkg for key numbers and the ROMs.
module keyboard_scancode_translator_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scancode,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [7:0] char_code,
    output logic       led_update,
    output logic       led_on
);

    // Input stage
    logic                              s1_valid_reg;
    logic [kst_pkg::SC_W-1:0]          s1_sc_reg;
    logic                              s1_advance;
    logic                              in_accept;

    // Key map
    logic [kst_pkg::NUM_KEYS-1:0]      map_reg;
    logic [kst_pkg::NUM_KEYS-1:0]      map_next;

    // Translation
    logic                              release_key;
    logic [kst_pkg::KEY_W-1:0]         key;
    logic                              is_caps;
    logic                              shift_held;
    logic [kst_pkg::CHAR_W-1:0]        rom_char;
    logic [kst_pkg::CHAR_W-1:0]        case_char;
    logic [kst_pkg::CHAR_W-1:0]        char_next;
    logic                              led_update_next;
    logic                              led_on_next;

    // Result stage
    logic                              r_valid_reg;
    logic                              char_valid_reg;
    logic [kst_pkg::CHAR_W-1:0]        char_code_reg;
    logic                              led_update_reg;
    logic                              led_on_reg;

    // Pipeline flow control
    assign s1_advance = !r_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // Hold the accepted scancode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sc_reg <= scancode;
        end
    end

    // Decode the held scancode
    assign release_key = s1_sc_reg[kst_pkg::REL_BIT];
    assign key         = s1_sc_reg[kst_pkg::KEY_W-1:0];
    assign is_caps     = !release_key && (key == kst_pkg::CAPS_KEY);

    // Update the key map: release clears, press sets, caps toggles the lock bit
    always_comb
    begin
        map_next      = map_reg;
        map_next[key] = !release_key;
        if (is_caps)
        begin
            map_next[kst_pkg::CAPS_LOCK_KEY] = !map_reg[kst_pkg::CAPS_LOCK_KEY];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else if (s1_valid_reg && s1_advance)
        begin
            map_reg <= map_next;
        end
    end

    // Look up the character against the updated modifier state
    assign shift_held = map_next[kst_pkg::LSHIFT_KEY] || map_next[kst_pkg::RSHIFT_KEY];
    assign rom_char   = shift_held ? kst_pkg::shift_rom(key) : kst_pkg::plain_rom(key);

    always_comb
    begin
        case_char = rom_char;
        if (map_next[kst_pkg::CAPS_LOCK_KEY] && (rom_char >= kst_pkg::CHAR_LOWER_A)
            && (rom_char <= kst_pkg::CHAR_LOWER_Z))
        begin
            case_char = rom_char - kst_pkg::CASE_OFFSET;
        end
    end

    always_comb
    begin
        if (release_key || is_caps)
        begin
            char_next = kst_pkg::CHAR_NONE;
        end
        else if (map_next[kst_pkg::CONTROL_KEY])
        begin
            char_next = case_char & kst_pkg::CTRL_MASK;
        end
        else
        begin
            char_next = case_char;
        end
    end

    assign led_update_next = is_caps;
    assign led_on_next     = is_caps && map_next[kst_pkg::CAPS_LOCK_KEY];

    // Advance into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            r_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_advance)
        begin
            char_valid_reg <= (char_next != kst_pkg::CHAR_NONE);
            char_code_reg  <= char_next;
            led_update_reg <= led_update_next;
            led_on_reg     <= led_on_next;
        end
    end

    assign out_valid  = r_valid_reg;
    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign led_update = led_update_reg;
    assign led_on     = led_on_reg;

endmodule

### rtl/kst_checker.sv
// Port-level checks for the scancode translator, bound to the top level.
// Depends on kst_pkg for character constants and on the top level's ports.
module kst_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       char_valid,
    input logic [7:0] char_code,
    input logic       led_update,
    input logic       led_on
);

    // Flag a character exactly when the code is nonzero
    a_char_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_valid == (char_code != kst_pkg::CHAR_NONE)))
        else $error("char_valid disagrees with char_code");

    // A caps toggle never yields a character
    a_caps_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && led_update) |-> !char_valid)
        else $error("caps toggle produced a character");

    // The LED state is only driven with an update
    a_led_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !led_update) |-> !led_on)
        else $error("led_on set without led_update");

    // Back-pressure upstream only while a result waits downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no waiting result");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(char_code)
            && $stable(led_update) && $stable(led_on)))
        else $error("stalled result changed");

endmodule

bind keyboard_scancode_translator_core kst_checker u_kst_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_valid (char_valid),
    .char_code  (char_code),
    .led_update (led_update),
    .led_on     (led_on)
);
